// File: rtl/core/fts_pkg.sv
package fts_pkg;

   localparam int unsigned POS_W  = 11;
   localparam int unsigned WALK_W = 12;
   localparam int unsigned AMT_W  = 32;
   localparam int unsigned SUM_W  = 64;

   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_SUM  = 2'd1;
   localparam logic [1:0] KIND_FIND = 2'd2;

   localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_SUM,
      ST_RESULT
   } fts_state_type;

endpackage

// File: rtl/core/fts_mem.sv
module fts_mem
   import fts_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
)
(
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [SUM_W-1:0]               wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [SUM_W-1:0]               rd_data
);

   logic [SUM_W-1:0] store_ff [DEPTH];
   logic [SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fenwick_tree_sum_search.sv
// Binary indexed tree of 64-bit sums over positions 1..n, n taken from the
// size register (clamped to 1..DEPTH, at most 2047). Requests arrive on the req_ channel
// and each gives exactly one transfer on the rsp_ channel: kind add updates
// the tree and returns zeros, kind prefix sum returns the sum of positions
// 1..position, kind find bisects for the smallest position whose prefix sum
// reaches the target. The size register is written through csr_wr_en and csr_wr_data;
// the user must write it only while the block is idle; the block does not enforce it.
// One item is handled at a time, with two 64-bit adders and one memory read port.
// A prefix sum walk reads one word per set bit of p, an add reads and writes each
// word of its lowbit chain; a find runs one walk for the total and one per
// bisection step, about 12 walks at a size of 1024. Each item then passes
// through the result and idle states.
// After reset the memory is cleared one word a cycle, all DEPTH words, during
// which req_ready is low. A finished result sits in the output register; a new
// request is taken while it waits, but the next result is held back until the
// receiver takes the pending one.
module fenwick_tree_sum_search
   import fts_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [AMT_W-1:0]   req_amount,
   input  logic signed [SUM_W-1:0]   req_target,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SUM_W-1:0]   rsp_sum_out,
   output logic [POS_W-1:0]          rsp_found_position,
   output logic                      rsp_found,
   input  logic                      csr_wr_en,
   input  logic [POS_W-1:0]          csr_wr_data
);

   localparam int unsigned AW   = $clog2(DEPTH);
   localparam int unsigned NCAP = (DEPTH < 2047) ? DEPTH : 2047;
   localparam logic [WALK_W-1:0] NCAP_W    = WALK_W'(NCAP);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);

   fts_state_type state_ff, state_in;
   logic [POS_W-1:0]         size_ff, size_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [1:0]               kind_ff, kind_in;
   logic [WALK_W-1:0]        n_ff, n_in;
   logic [WALK_W-1:0]        walk_ff, walk_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pend_addr_ff, pend_addr_in;
   logic [SUM_W-1:0]         acc_ff, acc_in;
   logic signed [AMT_W-1:0]  amt_ff, amt_in;
   logic signed [SUM_W-1:0]  tgt_ff, tgt_in;
   logic                     search_ff, search_in;
   logic [WALK_W-1:0]        lo_ff, lo_in;
   logic [WALK_W-1:0]        hi_ff, hi_in;
   logic [WALK_W-1:0]        ans_ff, ans_in;
   logic [WALK_W-1:0]        mid_ff, mid_in;
   logic [SUM_W-1:0]         res_sum_ff, res_sum_in;
   logic [POS_W-1:0]         res_pos_ff, res_pos_in;
   logic                     res_found_ff, res_found_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]         rsp_sum_ff, rsp_sum_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic                     rsp_found_ff, rsp_found_in;

   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [SUM_W-1:0]         mem_wdata;
   logic                     mem_re;
   logic [AW-1:0]            mem_raddr;
   logic [SUM_W-1:0]         mem_rdata;

   logic [WALK_W-1:0]        n_eff;
   logic [WALK_W-1:0]        pos_w;
   logic [WALK_W-1:0]        low_bit;
   logic [SUM_W-1:0]         amt_ext;
   logic                     reaches;
   logic [WALK_W-1:0]        lo_nx, hi_nx, ans_nx, mid_nx;
   logic [WALK_W:0]          mid_sum;
   logic                     go_on;
   logic                     rsp_load;

   fts_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      pos_w = {1'b0, req_position};
      if (size_ff == '0) begin
         n_eff = WALK_W'(1);
      end else if ({1'b0, size_ff} > NCAP_W) begin
         n_eff = NCAP_W;
      end else begin
         n_eff = {1'b0, size_ff};
      end
   end

   assign low_bit = walk_ff & (~walk_ff + WALK_W'(1));
   assign amt_ext = {{(SUM_W - AMT_W){amt_ff[AMT_W-1]}}, amt_ff};
   assign reaches = $signed(acc_ff) >= tgt_ff;

   // One bisection step: the first pass only checks the total against the target.
   always_comb begin
      if (!search_ff) begin
         lo_nx  = WALK_W'(1);
         hi_nx  = n_ff;
         ans_nx = '0;
         go_on  = reaches;
      end else begin
         if (reaches) begin
            lo_nx  = lo_ff;
            hi_nx  = mid_ff - WALK_W'(1);
            ans_nx = mid_ff;
         end else begin
            lo_nx  = mid_ff + WALK_W'(1);
            hi_nx  = hi_ff;
            ans_nx = ans_ff;
         end
         go_on = lo_nx <= hi_nx;
      end
      mid_sum = {1'b0, lo_nx} + {1'b0, hi_nx};
      mid_nx  = mid_sum[WALK_W:1];
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = csr_wr_en ? csr_wr_data : size_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      n_in         = n_ff;
      walk_in      = walk_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      acc_in       = acc_ff;
      amt_in       = amt_ff;
      tgt_in       = tgt_ff;
      search_in    = search_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ans_in       = ans_ff;
      mid_in       = mid_ff;
      res_sum_in   = res_sum_ff;
      res_pos_in   = res_pos_ff;
      res_found_in = res_found_ff;
      rsp_load     = 1'b0;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = pend_addr_ff;
      mem_wdata    = mem_rdata + amt_ext;
      mem_re       = 1'b0;
      mem_raddr    = AW'(walk_ff - WALK_W'(1));

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in      = req_kind;
               n_in         = n_eff;
               amt_in       = req_amount;
               tgt_in       = req_target;
               acc_in       = '0;
               pend_in      = 1'b0;
               search_in    = 1'b0;
               res_sum_in   = '0;
               res_pos_in   = '0;
               res_found_in = 1'b0;
               unique case (req_kind)
                  KIND_ADD: begin
                     // Position zero starts beyond the end so that the chain is empty.
                     walk_in  = (req_position == '0) ? n_eff + WALK_W'(1) : pos_w;
                     state_in = ST_ADD;
                  end
                  KIND_SUM: begin
                     walk_in  = (pos_w > n_eff) ? n_eff : pos_w;
                     state_in = ST_SUM;
                  end
                  KIND_FIND: begin
                     walk_in  = n_eff;
                     state_in = ST_SUM;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_ADD: begin
            // Each write lands in the cycle after its read; the chain never revisits a word.
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (walk_ff <= n_ff) begin
               mem_re       = 1'b1;
               pend_addr_in = AW'(walk_ff - WALK_W'(1));
               walk_in      = walk_ff + low_bit;
               pend_in      = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SUM: begin
            if (pend_ff) begin
               acc_in = acc_ff + mem_rdata;
            end
            if (walk_ff != '0) begin
               mem_re  = 1'b1;
               walk_in = walk_ff - low_bit;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (kind_ff == KIND_SUM) begin
                     res_sum_in = acc_ff;
                     state_in   = ST_RESULT;
                  end else if (go_on) begin
                     search_in = 1'b1;
                     lo_in     = lo_nx;
                     hi_in     = hi_nx;
                     ans_in    = ans_nx;
                     mid_in    = mid_nx;
                     walk_in   = mid_nx;
                     acc_in    = '0;
                  end else begin
                     res_pos_in   = ans_nx[POS_W-1:0];
                     res_found_in = ans_nx != '0;
                     state_in     = ST_RESULT;
                  end
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_sum_in   = rsp_load ? res_sum_ff : rsp_sum_ff;
      rsp_pos_in   = rsp_load ? res_pos_ff : rsp_pos_ff;
      rsp_found_in = rsp_load ? res_found_ff : rsp_found_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         size_ff      <= SIZE_RESET;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         search_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         search_ff    <= search_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      n_ff         <= n_in;
      walk_ff      <= walk_in;
      pend_addr_ff <= pend_addr_in;
      acc_ff       <= acc_in;
      amt_ff       <= amt_in;
      tgt_ff       <= tgt_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      ans_ff       <= ans_in;
      mid_ff       <= mid_in;
      res_sum_ff   <= res_sum_in;
      res_pos_ff   <= res_pos_in;
      res_found_ff <= res_found_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sum_out        = rsp_sum_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_found          = rsp_found_ff;

`ifndef SYNTHESIS
   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("memory written while idle");

   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken before the clearing pass");

   a_found_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_found_position != '0 && rsp_sum_out == '0)
      else $error("find result carries a bad position or a sum");

   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> state_ff == ST_ADD || state_ff == ST_SUM)
      else $error("memory read outside a walk");
`endif

endmodule

// File: dv/tb_fenwick_tree_sum_search.sv
module tb_fenwick_tree_sum_search;
   import fts_pkg::*;

   localparam int unsigned TREE_DEPTH     = 1024;
   localparam logic [1:0]  KIND_SPARE     = 2'd3;
   localparam longint      TIMEOUT_CYCLES = 1500000;
   localparam int          REPORT_LIMIT   = 10;

   typedef struct packed {
      logic signed [SUM_W-1:0] psum;
      logic [POS_W-1:0]        position;
      logic                    hit;
   } fenwick_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_kind = KIND_ADD;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [AMT_W-1:0] req_amount = '0;
   logic signed [SUM_W-1:0] req_target = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [SUM_W-1:0] rsp_sum_out;
   logic [POS_W-1:0]        rsp_found_position;
   logic                    rsp_found;
   logic                    csr_wr_en = 1'b0;
   logic [POS_W-1:0]        csr_wr_data = '0;

   fenwick_tree_sum_search dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_position       (req_position),
      .req_amount         (req_amount),
      .req_target         (req_target),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sum_out        (rsp_sum_out),
      .rsp_found_position (rsp_found_position),
      .rsp_found          (rsp_found),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // Mirror of the tree contents and size, with the queue of results still owed.
   class fenwick_scoreboard;
      logic [SUM_W-1:0]   tree_words [TREE_DEPTH];
      int unsigned        n_pos;
      fenwick_result_type owed_q [$];
      int                 faults;

      function new();
         foreach (tree_words[i]) tree_words[i] = '0;
         n_pos  = TREE_DEPTH;
         faults = 0;
      endfunction

      function void set_size(logic [POS_W-1:0] value);
         if (value == 0) begin
            n_pos = 1;
         end else if (value > TREE_DEPTH) begin
            n_pos = TREE_DEPTH;
         end else begin
            n_pos = 32'(value);
         end
      endfunction

      function int unsigned size_now();
         return n_pos;
      endfunction

      function logic [SUM_W-1:0] prefix_sum(int unsigned p);
         logic [SUM_W-1:0] acc;
         acc = '0;
         if (p > n_pos) p = n_pos;
         while (p != 0) begin
            acc += tree_words[p-1];
            p -= p & (~p + 1);
         end
         return acc;
      endfunction

      function void note_request(logic [1:0] kind, logic [POS_W-1:0] pos,
                                 logic signed [AMT_W-1:0] amt,
                                 logic signed [SUM_W-1:0] tgt);
         fenwick_result_type want;
         logic [SUM_W-1:0] amt_wide;
         int unsigned idx, lo, hi, mid;
         want = '0;
         amt_wide = {{(SUM_W-AMT_W){amt[AMT_W-1]}}, amt};
         case (kind)
            KIND_ADD: begin
               if (pos != 0 && pos <= n_pos) begin
                  idx = 32'(pos);
                  while (idx <= n_pos) begin
                     tree_words[idx-1] += amt_wide;
                     idx += idx & (~idx + 1);
                  end
               end
            end
            KIND_SUM: want.psum = prefix_sum(32'(pos));
            KIND_FIND: begin
               // The search runs over full prefix sums even when they are not
               // monotone, so it is reproduced step for step.
               if ($signed(prefix_sum(n_pos)) >= tgt) begin
                  lo = 1;
                  hi = n_pos;
                  while (lo <= hi) begin
                     mid = (lo + hi) / 2;
                     if ($signed(prefix_sum(mid)) >= tgt) begin
                        want.position = POS_W'(mid);
                        want.hit = 1'b1;
                        hi = mid - 1;
                     end else begin
                        lo = mid + 1;
                     end
                  end
               end
            end
            default: ;
         endcase
         owed_q.push_back(want);
      endfunction

      function void check_result(logic signed [SUM_W-1:0] psum, logic [POS_W-1:0] position,
                                 logic hit);
         fenwick_result_type want;
         if (owed_q.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("unexpected result: sum %0d position %0d found %0b",
                        psum, position, hit);
            return;
         end
         want = owed_q.pop_front();
         if (psum !== want.psum || position !== want.position || hit !== want.hit) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display({"mismatch: expected sum %0d position %0d found %0b, ",
                         "got sum %0d position %0d found %0b"},
                        want.psum, want.position, want.hit, psum, position, hit);
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   fenwick_scoreboard sb;
   int unsigned burst_left = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   always #5 clock = ~clock;

   // Receiver: checks every transfer and switches between stall patterns.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_sum_out, rsp_found_position, rsp_found);
      end
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(5, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ~rsp_ready;
      endcase
   end

   // Valid is left high on return, so that a back-to-back item needs no second
   // assignment in the same step.
   task automatic send_item(logic [1:0] kind, logic [POS_W-1:0] pos,
                            logic signed [AMT_W-1:0] amt, logic signed [SUM_W-1:0] tgt);
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= pos;
      req_amount   <= amt;
      req_target   <= tgt;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, pos, amt, tgt);
   endtask

   task automatic pace();
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(logic [POS_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      sb.set_size(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic directed_item(logic [1:0] kind, logic [POS_W-1:0] pos,
                                logic signed [AMT_W-1:0] amt, logic signed [SUM_W-1:0] tgt);
      send_item(kind, pos, amt, tgt);
      pace();
   endtask

   task automatic random_item();
      logic [1:0]              kind;
      logic [POS_W-1:0]        pos;
      logic signed [AMT_W-1:0] amt;
      logic signed [SUM_W-1:0] tgt;
      logic signed [SUM_W-1:0] total;
      int unsigned             n;
      int unsigned             roll;
      n = sb.size_now();
      total = sb.prefix_sum(n);
      roll = $urandom_range(0, 99);
      if (roll < 45) kind = KIND_ADD;
      else if (roll < 70) kind = KIND_SUM;
      else if (roll < 95) kind = KIND_FIND;
      else kind = KIND_SPARE;

      roll = $urandom_range(0, 9);
      if (roll == 0) pos = '0;
      else if (roll == 1) pos = POS_W'($urandom_range(n + 1, 2047));
      else if (roll == 2) pos = POS_W'($urandom);
      else pos = POS_W'($urandom_range(1, n));

      roll = $urandom_range(0, 9);
      if (roll < 7) amt = AMT_W'($urandom_range(0, 1000));
      else if (roll < 9) amt = 0 - AMT_W'($urandom_range(1, 1000));
      else amt = $urandom;

      tgt = {$urandom, $urandom};
      if (kind == KIND_FIND) begin
         // Most targets sit at or just under the total so that the search
         // ends somewhere inside the tree.
         roll = $urandom_range(0, 9);
         case (roll)
            5: tgt = total;
            6: tgt = total + 1;
            7: ;
            8: tgt = 0 - SUM_W'($urandom_range(0, 1000));
            9: tgt = $urandom_range(0, 1) ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            default: tgt = total - SUM_W'($urandom_range(0, 300));
         endcase
      end
      send_item(kind, pos, amt, tgt);
      pace();
   endtask

   initial begin
      logic [POS_W-1:0] phase_size [7];
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The store is cleared word by word after reset; ready stays low until then.
      while (!req_ready) @(posedge clock);
      write_size(SIZE_RESET);

      directed_item(KIND_SUM,  11'd0,    32'sd0, 64'sd0);
      directed_item(KIND_FIND, 11'd1,    32'sd0, 64'sd0);
      directed_item(KIND_FIND, 11'd1,    32'sd0, 64'sd1);
      directed_item(KIND_ADD,  11'd0,    32'sd5, 64'sd0);
      directed_item(KIND_ADD,  11'd1,    32'h7fffffff, 64'sd0);
      directed_item(KIND_ADD,  11'd1024, 32'h80000000, 64'sd0);
      directed_item(KIND_ADD,  11'd2047, 32'sd77, 64'sd0);
      directed_item(KIND_ADD,  11'd1025, 32'sd9, 64'sd0);
      directed_item(KIND_ADD,  11'd512,  32'sd100, 64'sd0);
      directed_item(KIND_ADD,  11'd3,    -32'sd1, 64'sd0);
      directed_item(KIND_SUM,  11'd1,    32'sd0, 64'sd0);
      directed_item(KIND_SUM,  11'd512,  32'sd0, 64'sd0);
      directed_item(KIND_SUM,  11'd1024, 32'sd0, 64'sd0);
      directed_item(KIND_SUM,  11'd2047, 32'sd0, 64'sd0);
      directed_item(KIND_FIND, 11'd0,    32'sd0, 64'h7fffffffffffffff);
      directed_item(KIND_FIND, 11'd0,    32'sd0, 64'h8000000000000000);
      directed_item(KIND_FIND, 11'd0,    32'sd0, 64'sd98);
      directed_item(KIND_FIND, 11'd0,    32'sd0, 64'sd2147483647);
      directed_item(KIND_SPARE, 11'h7ff, 32'hffffffff, 64'hffffffffffffffff);
      directed_item(KIND_ADD,  11'd1024, 32'h7fffffff, 64'sd0);
      directed_item(KIND_FIND, 11'd0,    32'sd0, 64'sd2147483746);
      directed_item(KIND_FIND, 11'd0,    32'sd0, 64'sd2147483747);

      phase_size[0] = 11'd1;
      phase_size[1] = 11'd0;
      phase_size[2] = 11'd2047;
      phase_size[3] = POS_W'($urandom_range(2, 40));
      phase_size[4] = SIZE_RESET;
      phase_size[5] = POS_W'($urandom_range(2, 1023));
      phase_size[6] = 11'd16;
      foreach (phase_size[i]) begin
         drain();
         write_size(phase_size[i]);
         repeat (60) begin
            random_item();
            if ($urandom_range(0, 39) == 0) drain();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.faults == 0 && sb.pending() == 0) begin
         $display("PASS fenwick_tree_sum_search");
      end else begin
         $display("FAIL fenwick_tree_sum_search");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("FAIL fenwick_tree_sum_search");
      $finish;
   end

endmodule
